### rtl/sc3s_pkg.sv
// Package of the strided 3x3 convolution stream: payload types, kernel and
// window types, register indexes and the stage tag passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package sc3s_pkg;

	localparam int KSIZE = 3;

	localparam int PIX_W   = 8;
	localparam int COEF_W  = 16;
	localparam int PROD_W  = PIX_W + 1 + COEF_W;
	localparam int ACC_W   = PROD_W + 4;
	localparam int SUM_W   = 28;
	localparam int CFG_W   = 48;
	localparam int ROW_W   = 10;
	localparam int STEP_W  = 3;
	localparam int PHASE_W = 2;
	localparam int IMGW_W  = 6;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [KSIZE-1:0] krow_t;
	typedef krow_t [KSIZE-1:0] kernel_t;
	typedef pix_t [KSIZE-1:0] wrow_t;
	typedef wrow_t [KSIZE-1:0] window_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef enum logic [2:0] {
		REG_KERNEL_TOP    = 3'd0,
		REG_KERNEL_MIDDLE = 3'd1,
		REG_KERNEL_BOTTOM = 3'd2,
		REG_IMAGE_WIDTH   = 3'd3,
		REG_IMAGE_HEIGHT  = 3'd4,
		REG_STEP_SIZE     = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
	} pix_in_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] conv_sum;
		logic                    last_of_image;
	} result_t;

	typedef struct packed {
		logic [2:0]       index;
		logic [CFG_W-1:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic produce;
		logic last;
	} tag_t;

endpackage

### rtl/sc3s_chan_if.sv
// Valid/ready channel interface used for the pixel, result and configuration ports.
// The payload type is a parameter; the types come from sc3s_pkg.
`timescale 1ns / 1ps

interface sc3s_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

### rtl/sc3s_ctrl.sv
// Configuration registers, raster position counters and stride phase tracking.
// Registers each accepted pixel with its result tag; depends on sc3s_pkg and sc3s_chan_if.
`timescale 1ns / 1ps

module sc3s_ctrl #(
	parameter int MAX_WIDTH = 32,
	parameter int COLW      = $clog2(MAX_WIDTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sc3s_chan_if.sink            pix,
	sc3s_chan_if.sink            cfg,
	input  logic                 s1_ready,
	output logic                 s1_v,
	output sc3s_pkg::pix_t       pixel_s1,
	output logic [COLW-1:0]      col_s1,
	output sc3s_pkg::tag_t       tag_s1,
	output logic                 rd_en,
	output logic [COLW-1:0]      rd_addr,
	output sc3s_pkg::kernel_t    kernel
);

	localparam int EW   = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = ((EW > sc3s_pkg::IMGW_W) ? EW : sc3s_pkg::IMGW_W) + 2;
	localparam int RW   = sc3s_pkg::ROW_W + 1;

	sc3s_pkg::kernel_t                kernel_q;
	logic [sc3s_pkg::IMGW_W-1:0]      width_q;
	logic [sc3s_pkg::ROW_W-1:0]       height_q;
	logic [sc3s_pkg::STEP_W-1:0]      step_q;
	logic [sc3s_pkg::ROW_W-1:0]       row_q;
	logic [COLW-1:0]                  col_q;
	logic [sc3s_pkg::PHASE_W-1:0]     row_ph_q;
	logic [sc3s_pkg::PHASE_W-1:0]     col_ph_q;
	logic                             s1_v_q;

	logic [CMPW-1:0]                  iw_ext;
	logic [CMPW-1:0]                  eff_w;
	logic [RW-1:0]                    eff_h;
	logic [sc3s_pkg::STEP_W-1:0]      eff_s;
	logic [CMPW-1:0]                  col_ext;
	logic [RW-1:0]                    row_ext;
	logic                             col_last;
	logic                             row_last;
	logic                             row_ok;
	logic                             col_ok;
	logic [sc3s_pkg::PHASE_W-1:0]     row_ph_inc;
	logic [sc3s_pkg::PHASE_W-1:0]     col_ph_inc;
	logic                             accept;
	logic                             cfg_wr;
	sc3s_pkg::tag_t                   tag_d;

	assign iw_ext  = CMPW'(width_q);
	assign col_ext = CMPW'(col_q);
	assign row_ext = RW'(row_q);

	always_comb begin
		if (width_q < sc3s_pkg::IMGW_W'(3)) begin
			eff_w = CMPW'(3);
		end else if (iw_ext > CMPW'(MAX_WIDTH)) begin
			eff_w = CMPW'(MAX_WIDTH);
		end else begin
			eff_w = iw_ext;
		end
		eff_h = (height_q < sc3s_pkg::ROW_W'(3)) ? RW'(3) : RW'(height_q);
		if (step_q == '0) begin
			eff_s = sc3s_pkg::STEP_W'(1);
		end else if (step_q > sc3s_pkg::STEP_W'(4)) begin
			eff_s = sc3s_pkg::STEP_W'(4);
		end else begin
			eff_s = step_q;
		end
	end

	always_comb begin
		col_last = (col_ext + CMPW'(1)) >= eff_w;
		row_last = (row_ext + RW'(1)) >= eff_h;
		row_ok   = row_q >= sc3s_pkg::ROW_W'(2);
		col_ok   = col_q >= COLW'(2);
		row_ph_inc = ((sc3s_pkg::STEP_W'(row_ph_q) + sc3s_pkg::STEP_W'(1)) == eff_s) ?
			'0 : row_ph_q + sc3s_pkg::PHASE_W'(1);
		col_ph_inc = ((sc3s_pkg::STEP_W'(col_ph_q) + sc3s_pkg::STEP_W'(1)) == eff_s) ?
			'0 : col_ph_q + sc3s_pkg::PHASE_W'(1);
		tag_d.produce = row_ok && col_ok && (row_ph_q == '0) && (col_ph_q == '0);
		tag_d.last    = ((row_ext + RW'(eff_s) + RW'(1)) > eff_h) &&
			((col_ext + CMPW'(eff_s) + CMPW'(1)) > eff_w);
	end

	assign pix.ready = !s1_v_q || s1_ready;
	assign accept    = pix.valid && pix.ready;
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	assign rd_en   = accept;
	assign rd_addr = col_q;
	assign s1_v    = s1_v_q;
	assign kernel  = kernel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= '0;
			width_q  <= sc3s_pkg::IMGW_W'(28);
			height_q <= sc3s_pkg::ROW_W'(28);
			step_q   <= sc3s_pkg::STEP_W'(1);
			row_q    <= '0;
			col_q    <= '0;
			row_ph_q <= '0;
			col_ph_q <= '0;
		end else begin
			if (accept) begin
				if (col_last) begin
					col_q    <= '0;
					col_ph_q <= '0;
					if (row_last) begin
						row_q    <= '0;
						row_ph_q <= '0;
					end else begin
						row_q    <= row_q + sc3s_pkg::ROW_W'(1);
						row_ph_q <= row_ok ? row_ph_inc : '0;
					end
				end else begin
					col_q    <= col_q + COLW'(1);
					col_ph_q <= col_ok ? col_ph_inc : '0;
				end
			end
			if (cfg_wr) begin
				case (cfg.payload.index)
					sc3s_pkg::REG_KERNEL_TOP: begin
						kernel_q[0] <= cfg.payload.wdata;
					end
					sc3s_pkg::REG_KERNEL_MIDDLE: begin
						kernel_q[1] <= cfg.payload.wdata;
					end
					sc3s_pkg::REG_KERNEL_BOTTOM: begin
						kernel_q[2] <= cfg.payload.wdata;
					end
					sc3s_pkg::REG_IMAGE_WIDTH: begin
						width_q  <= cfg.payload.wdata[sc3s_pkg::IMGW_W-1:0];
						row_q    <= '0;
						col_q    <= '0;
						row_ph_q <= '0;
						col_ph_q <= '0;
					end
					sc3s_pkg::REG_IMAGE_HEIGHT: begin
						height_q <= cfg.payload.wdata[sc3s_pkg::ROW_W-1:0];
						row_q    <= '0;
						col_q    <= '0;
						row_ph_q <= '0;
						col_ph_q <= '0;
					end
					sc3s_pkg::REG_STEP_SIZE: begin
						step_q   <= cfg.payload.wdata[sc3s_pkg::STEP_W-1:0];
						row_q    <= '0;
						col_q    <= '0;
						row_ph_q <= '0;
						col_ph_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (s1_ready) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pix.payload.pixel;
			col_s1   <= col_q;
			tag_s1   <= tag_d;
		end
	end

`ifndef ASSERT_OFF
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_ext < eff_w)
		else $error("column position reached the image width");

	a_phase_below_step: assert property (@(posedge clk) disable iff (!arst_n)
		(sc3s_pkg::STEP_W'(row_ph_q) < eff_s) && (sc3s_pkg::STEP_W'(col_ph_q) < eff_s))
		else $error("stride phase out of range");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && tag_s1.produce |-> col_s1 >= COLW'(2))
		else $error("result tagged before the window is complete");
`endif

endmodule

### rtl/sc3s_line_buf.sv
// Two line stores and the 3x3 pixel window, which also serves as the window stage register.
// Depends on sc3s_pkg.
`timescale 1ns / 1ps

module sc3s_line_buf #(
	parameter int MAX_WIDTH = 32,
	parameter int COLW      = $clog2(MAX_WIDTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [COLW-1:0]     rd_addr,
	input  logic                s1_v,
	output logic                s1_ready,
	input  sc3s_pkg::pix_t      pixel_s1,
	input  logic [COLW-1:0]     col_s1,
	input  sc3s_pkg::tag_t      tag_s1,
	output logic                s2_v,
	output sc3s_pkg::window_t   win_s2,
	output logic                last_s2,
	input  logic                mac_ready
);

	sc3s_pkg::pix_t    top_mem [MAX_WIDTH];
	sc3s_pkg::pix_t    mid_mem [MAX_WIDTH];
	sc3s_pkg::pix_t    top_rd_q;
	sc3s_pkg::pix_t    mid_rd_q;
	sc3s_pkg::window_t win_q;
	logic              s2_v_q;
	logic              last_q;
	logic              s1_fire;

	assign s1_ready = !s2_v_q || mac_ready;
	assign s1_fire  = s1_v && s1_ready;
	assign s2_v     = s2_v_q;
	assign win_s2   = win_q;
	assign last_s2  = last_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			top_rd_q <= top_mem[rd_addr];
			mid_rd_q <= mid_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			top_mem[col_s1] <= mid_rd_q;
			mid_mem[col_s1] <= pixel_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			s2_v_q <= 1'b0;
			last_q <= 1'b0;
		end else if (s1_fire) begin
			for (int i = 0; i < sc3s_pkg::KSIZE; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= top_rd_q;
			win_q[1][2] <= mid_rd_q;
			win_q[2][2] <= pixel_s1;
			s2_v_q      <= tag_s1.produce;
			last_q      <= tag_s1.last;
		end else if (mac_ready) begin
			s2_v_q <= 1'b0;
		end
	end

endmodule

### rtl/sc3s_mac.sv
// Nine parallel pixel-by-coefficient products, a product register, the window sum
// and the result register. Depends on sc3s_pkg and sc3s_chan_if.
`timescale 1ns / 1ps

module sc3s_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s2_v,
	input  sc3s_pkg::window_t  win_s2,
	input  logic               last_s2,
	output logic               mac_ready,
	input  sc3s_pkg::kernel_t  kernel,
	sc3s_chan_if.source        res
);

	sc3s_pkg::prod_t prod_d  [sc3s_pkg::KSIZE][sc3s_pkg::KSIZE];
	sc3s_pkg::prod_t prod_s3 [sc3s_pkg::KSIZE][sc3s_pkg::KSIZE];
	logic            valid_s3;
	logic            last_s3;
	logic            out_v_q;
	logic            out_rdy;
	sc3s_pkg::acc_t  acc;
	sc3s_pkg::result_t res_q;

	assign out_rdy   = !out_v_q || res.ready;
	assign mac_ready = !valid_s3 || out_rdy;

	always_comb begin
		for (int i = 0; i < sc3s_pkg::KSIZE; i++) begin
			for (int j = 0; j < sc3s_pkg::KSIZE; j++) begin
				prod_d[i][j] = sc3s_pkg::PROD_W'($signed({1'b0, win_s2[i][j]})) *
					sc3s_pkg::PROD_W'($signed(kernel[i][j]));
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < sc3s_pkg::KSIZE; i++) begin
			for (int j = 0; j < sc3s_pkg::KSIZE; j++) begin
				acc = acc + sc3s_pkg::ACC_W'(prod_s3[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_v && mac_ready) begin
			prod_s3 <= prod_d;
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (mac_ready) begin
			valid_s3 <= s2_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_rdy) begin
			out_v_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && out_rdy) begin
			res_q.conv_sum      <= acc[sc3s_pkg::SUM_W-1:0];
			res_q.last_of_image <= last_s3;
		end
	end

	assign res.valid   = out_v_q;
	assign res.payload = res_q;

endmodule

### rtl/strided_convolution_3x3_stream.sv
// Top level of the strided 3x3 convolution stream.
// Instantiates sc3s_ctrl, sc3s_line_buf and sc3s_mac; depends on sc3s_pkg and sc3s_chan_if.
//
// Usage: pixels of an 8-bit grayscale image enter on the pix channel in raster
// order, one transaction per pixel. A transaction on cfg writes one register:
// index 0 to 2 are the kernel rows, 3 the image width, 4 the height, 5 the stride.
// The user writes registers only while the block is idle; the block does not enforce it.
// A geometry write starts a new image. For every window whose top-left corner lies on the
// stride grid, one transaction leaves on res with the full-precision sum and a flag on the
// final result of the image. Throughput is one pixel per clock cycle while res is not
// stalled: each pixel passes an input register, the line store read and window shift,
// the product register and the result register, from which the result leaves on res.
// When the receiver stalls, the stages fill up and pix.ready drops only once the result
// register, the product register, the window and the input register all hold an item.
// Reset clears the positions, the window and all valid flags, sets the kernel to
// zero, the image to 28 by 28 pixels and the stride to one. The line stores are not
// cleared, since their contents only reach windows that give no result.
`timescale 1ns / 1ps

module strided_convolution_3x3_stream #(
	parameter int MAX_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	sc3s_chan_if.sink   pix,
	sc3s_chan_if.sink   cfg,
	sc3s_chan_if.source res
);

	localparam int COLW = $clog2(MAX_WIDTH);

	logic                s1_ready;
	logic                s1_v;
	sc3s_pkg::pix_t      pixel_s1;
	logic [COLW-1:0]     col_s1;
	sc3s_pkg::tag_t      tag_s1;
	logic                rd_en;
	logic [COLW-1:0]     rd_addr;
	sc3s_pkg::kernel_t   kernel;
	logic                s2_v;
	sc3s_pkg::window_t   win_s2;
	logic                last_s2;
	logic                mac_ready;

	sc3s_ctrl #(
		.MAX_WIDTH(MAX_WIDTH),
		.COLW(COLW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.cfg(cfg),
		.s1_ready(s1_ready),
		.s1_v(s1_v),
		.pixel_s1(pixel_s1),
		.col_s1(col_s1),
		.tag_s1(tag_s1),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.kernel(kernel)
	);

	sc3s_line_buf #(
		.MAX_WIDTH(MAX_WIDTH),
		.COLW(COLW)
	) u_line_buf (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.s1_v(s1_v),
		.s1_ready(s1_ready),
		.pixel_s1(pixel_s1),
		.col_s1(col_s1),
		.tag_s1(tag_s1),
		.s2_v(s2_v),
		.win_s2(win_s2),
		.last_s2(last_s2),
		.mac_ready(mac_ready)
	);

	sc3s_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.s2_v(s2_v),
		.win_s2(win_s2),
		.last_s2(last_s2),
		.mac_ready(mac_ready),
		.kernel(kernel),
		.res(res)
	);

endmodule

### sim/tb_strided_convolution_3x3_stream.sv
// Self-checking testbench of strided_convolution_3x3_stream. It predicts every window sum
// and end-of-image flag from the accepted pixels and register writes.
// Depends on sc3s_pkg, sc3s_chan_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_strided_convolution_3x3_stream;

	localparam int LINE_DEPTH = 32;
	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_ITEMS = 2000;
	localparam logic [2:0] REG_UNUSED_A = 3'd6;
	localparam logic [2:0] REG_UNUSED_B = 3'd7;
	localparam logic [sc3s_pkg::COEF_W-1:0] COEF_MAX = 16'h7FFF;
	localparam logic [sc3s_pkg::COEF_W-1:0] COEF_MIN = 16'h8000;
	localparam sc3s_pkg::pix_t PIX_FULL = 8'hFF;

	class conv_window_model;
		logic [sc3s_pkg::CFG_W-1:0] kern [sc3s_pkg::KSIZE];
		int unsigned width_reg;
		int unsigned height_reg;
		int unsigned step_reg;
		sc3s_pkg::pix_t line_mem [2*LINE_DEPTH];
		sc3s_pkg::pix_t win [sc3s_pkg::KSIZE][sc3s_pkg::KSIZE];
		int unsigned row_pos;
		int unsigned col_pos;
		sc3s_pkg::result_t expected_sums [$];
		int mismatches;

		function new();
			for (int i = 0; i < sc3s_pkg::KSIZE; i++) begin
				kern[i] = '0;
				for (int j = 0; j < sc3s_pkg::KSIZE; j++) begin
					win[i][j] = '0;
				end
			end
			foreach (line_mem[i]) begin
				line_mem[i] = '0;
			end
			width_reg = 28;
			height_reg = 28;
			step_reg = 1;
			row_pos = 0;
			col_pos = 0;
			mismatches = 0;
		endfunction

		function int unsigned eff_width();
			if (width_reg < 3) return 3;
			if (width_reg > LINE_DEPTH) return LINE_DEPTH;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			return (height_reg < 3) ? 3 : height_reg;
		endfunction

		function int unsigned eff_step();
			if (step_reg < 1) return 1;
			if (step_reg > 4) return 4;
			return step_reg;
		endfunction

		function int pending();
			return expected_sums.size();
		endfunction

		function void write_reg(logic [2:0] idx, logic [sc3s_pkg::CFG_W-1:0] data);
			case (idx)
				sc3s_pkg::REG_KERNEL_TOP, sc3s_pkg::REG_KERNEL_MIDDLE,
				sc3s_pkg::REG_KERNEL_BOTTOM: begin
					kern[idx] = data;
				end
				sc3s_pkg::REG_IMAGE_WIDTH: begin
					width_reg = 32'(data[sc3s_pkg::IMGW_W-1:0]);
					row_pos = 0;
					col_pos = 0;
				end
				sc3s_pkg::REG_IMAGE_HEIGHT: begin
					height_reg = 32'(data[sc3s_pkg::ROW_W-1:0]);
					row_pos = 0;
					col_pos = 0;
				end
				sc3s_pkg::REG_STEP_SIZE: begin
					step_reg = 32'(data[sc3s_pkg::STEP_W-1:0]);
					row_pos = 0;
					col_pos = 0;
				end
				default: begin
				end
			endcase
		endfunction

		function void take_pixel(sc3s_pkg::pix_t px);
			int unsigned ew;
			int unsigned eh;
			int unsigned es;
			int unsigned ci;
			sc3s_pkg::pix_t top;
			sc3s_pkg::pix_t mid;
			longint acc;
			sc3s_pkg::result_t want;
			ew = eff_width();
			eh = eff_height();
			es = eff_step();
			ci = col_pos % LINE_DEPTH;
			top = line_mem[ci];
			mid = line_mem[LINE_DEPTH+ci];
			line_mem[ci] = mid;
			line_mem[LINE_DEPTH+ci] = px;
			for (int i = 0; i < sc3s_pkg::KSIZE; i++) begin
				for (int j = 0; j < sc3s_pkg::KSIZE - 1; j++) begin
					win[i][j] = win[i][j+1];
				end
			end
			win[0][sc3s_pkg::KSIZE-1] = top;
			win[1][sc3s_pkg::KSIZE-1] = mid;
			win[2][sc3s_pkg::KSIZE-1] = px;
			if (row_pos >= sc3s_pkg::KSIZE - 1 && col_pos >= sc3s_pkg::KSIZE - 1 &&
			    (row_pos - (sc3s_pkg::KSIZE - 1)) % es == 0 &&
			    (col_pos - (sc3s_pkg::KSIZE - 1)) % es == 0) begin
				acc = 0;
				for (int i = 0; i < sc3s_pkg::KSIZE; i++) begin
					for (int j = 0; j < sc3s_pkg::KSIZE; j++) begin
						acc += longint'(win[i][j]) * longint'(sc3s_pkg::coef_t'(
							kern[i][sc3s_pkg::COEF_W*j +: sc3s_pkg::COEF_W]));
					end
				end
				want.conv_sum = acc[sc3s_pkg::SUM_W-1:0];
				want.last_of_image = (row_pos + es + 1 > eh) && (col_pos + es + 1 > ew);
				expected_sums.push_back(want);
			end
			if (col_pos + 1 >= ew) begin
				col_pos = 0;
				row_pos = (row_pos + 1 >= eh) ? 0 : row_pos + 1;
			end else begin
				col_pos = col_pos + 1;
			end
		endfunction

		function void check_sum(sc3s_pkg::result_t got);
			sc3s_pkg::result_t want;
			if (expected_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: conv_sum %0d last_of_image %0b",
						got.conv_sum, got.last_of_image);
				end
			end else begin
				want = expected_sums.pop_front();
				if (got.conv_sum !== want.conv_sum ||
				    got.last_of_image !== want.last_of_image) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display({"result mismatch: conv_sum expected %0d actual %0d, ",
							"last_of_image expected %0b actual %0b"},
							want.conv_sum, got.conv_sum, want.last_of_image,
							got.last_of_image);
					end
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sc3s_chan_if #(.payload_t(sc3s_pkg::pix_in_t)) pix_if ();
	sc3s_chan_if #(.payload_t(sc3s_pkg::cfg_wr_t)) cfg_if ();
	sc3s_chan_if #(.payload_t(sc3s_pkg::result_t)) res_if ();

	strided_convolution_3x3_stream #(.MAX_WIDTH(LINE_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_if),
		.cfg    (cfg_if),
		.res    (res_if)
	);

	conv_window_model model;
	int send_idle_pct;
	int recv_idle_pct;
	int pixels_sent;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pix_if.valid && pix_if.ready) begin
			model.take_pixel(pix_if.payload.pixel);
		end
	end

	always @(posedge clk) begin
		if (arst_n && cfg_if.valid && cfg_if.ready) begin
			model.write_reg(cfg_if.payload.index, cfg_if.payload.wdata);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			model.check_sum(res_if.payload);
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_strided_convolution_3x3_stream failed");
		$finish;
	end

	function automatic logic [sc3s_pkg::COEF_W-1:0] pick_coef();
		case ($urandom_range(3))
			0: return COEF_MAX;
			1: return COEF_MIN;
			default: return sc3s_pkg::COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic [sc3s_pkg::CFG_W-1:0] random_kernel_row();
		return {pick_coef(), pick_coef(), pick_coef()};
	endfunction

	function automatic logic [sc3s_pkg::CFG_W-1:0] random_word();
		return sc3s_pkg::CFG_W'({$urandom, $urandom});
	endfunction

	function automatic sc3s_pkg::pix_t random_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return PIX_FULL;
			default: return sc3s_pkg::PIX_W'($urandom_range(255));
		endcase
	endfunction

	task automatic send_pixel(sc3s_pkg::pix_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.payload <= '{pixel: px};
		@(posedge clk);
		while (!pix_if.ready) begin
			@(posedge clk);
		end
		pixels_sent++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [sc3s_pkg::CFG_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.payload <= '{index: idx, wdata: data};
		@(posedge clk);
		while (!cfg_if.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic close_config();
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		pix_if.valid <= 1'b0;
		@(posedge clk);
		while (model.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_kernel(logic [sc3s_pkg::CFG_W-1:0] k0,
		logic [sc3s_pkg::CFG_W-1:0] k1, logic [sc3s_pkg::CFG_W-1:0] k2);
		write_reg(sc3s_pkg::REG_KERNEL_TOP, k0);
		write_reg(sc3s_pkg::REG_KERNEL_MIDDLE, k1);
		write_reg(sc3s_pkg::REG_KERNEL_BOTTOM, k2);
	endtask

	task automatic write_geometry(logic [sc3s_pkg::CFG_W-1:0] w,
		logic [sc3s_pkg::CFG_W-1:0] h, logic [sc3s_pkg::CFG_W-1:0] s);
		write_reg(sc3s_pkg::REG_IMAGE_WIDTH, w);
		write_reg(sc3s_pkg::REG_IMAGE_HEIGHT, h);
		write_reg(sc3s_pkg::REG_STEP_SIZE, s);
	endtask

	task automatic run_phase(bit extreme);
		logic [sc3s_pkg::CFG_W-1:0] data;
		int area;
		int n;
		wait_idle();
		if (extreme) begin
			write_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
			write_geometry(48'd32, 48'd5, 48'd4);
		end else begin
			if ($urandom_range(3) != 0) begin
				write_reg(sc3s_pkg::REG_KERNEL_TOP, random_kernel_row());
			end
			if ($urandom_range(3) != 0) begin
				write_reg(sc3s_pkg::REG_KERNEL_MIDDLE, random_kernel_row());
			end
			if ($urandom_range(3) != 0) begin
				write_reg(sc3s_pkg::REG_KERNEL_BOTTOM, random_kernel_row());
			end
			if ($urandom_range(3) != 0) begin
				data = random_word();
				if ($urandom_range(9) == 0) begin
					data[sc3s_pkg::IMGW_W-1:0] = $urandom_range(1) ?
						sc3s_pkg::IMGW_W'($urandom_range(0, 2)) :
						sc3s_pkg::IMGW_W'($urandom_range(33, 63));
				end else begin
					data[sc3s_pkg::IMGW_W-1:0] = sc3s_pkg::IMGW_W'($urandom_range(3, 32));
				end
				write_reg(sc3s_pkg::REG_IMAGE_WIDTH, data);
			end
			if ($urandom_range(3) != 0) begin
				data = random_word();
				case ($urandom_range(9))
					0: data[sc3s_pkg::ROW_W-1:0] = sc3s_pkg::ROW_W'($urandom_range(0, 2));
					1: data[sc3s_pkg::ROW_W-1:0] = sc3s_pkg::ROW_W'($urandom_range(500, 1023));
					default: data[sc3s_pkg::ROW_W-1:0] = sc3s_pkg::ROW_W'($urandom_range(3, 12));
				endcase
				write_reg(sc3s_pkg::REG_IMAGE_HEIGHT, data);
			end
			if ($urandom_range(3) != 0) begin
				data = random_word();
				data[sc3s_pkg::STEP_W-1:0] = sc3s_pkg::STEP_W'($urandom_range(0, 7));
				write_reg(sc3s_pkg::REG_STEP_SIZE, data);
			end
			if ($urandom_range(7) == 0) begin
				write_reg($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B, random_word());
			end
		end
		close_config();
		area = model.eff_width() * model.eff_height();
		if (area <= 150) begin
			n = area * $urandom_range(1, 2);
			if ($urandom_range(3) == 0) n += $urandom_range(0, area - 1);
		end else begin
			n = $urandom_range(60, 300);
		end
		repeat (n) send_pixel(random_pixel());
	endtask

	initial begin
		int profile;
		model = new();
		send_idle_pct = 20;
		recv_idle_pct = 69;
		pixels_sent = 0;
		arst_n = 1'b0;
		pix_if.valid <= 1'b0;
		pix_if.payload <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.payload <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_kernel({3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}});
		write_geometry(48'd3, 48'd3, 48'd1);
		close_config();
		repeat (9) send_pixel(PIX_FULL);
		wait_idle();
		write_kernel({3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}});
		close_config();
		repeat (9) send_pixel(PIX_FULL);
		wait_idle();
		write_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
		write_geometry(48'd0, 48'd2, 48'd7);
		write_reg(REG_UNUSED_A, random_word());
		write_reg(REG_UNUSED_B, random_word());
		close_config();
		repeat (9) send_pixel(random_pixel());

		pixels_sent = 0;
		for (profile = 0; profile < 3; profile++) begin
			send_idle_pct = (profile == 0) ? 20 : (profile == 1) ? 69 : 0;
			recv_idle_pct = (profile == 0) ? 69 : (profile == 1) ? 20 : 0;
			run_phase(1'b1);
			while (pixels_sent < (profile + 1) * RANDOM_ITEMS / 3) begin
				run_phase(1'b0);
			end
		end

		wait_idle();
		if (model.mismatches == 0 && model.pending() == 0) begin
			$display("tb_strided_convolution_3x3_stream passed");
		end else begin
			$display("tb_strided_convolution_3x3_stream failed");
		end
		$finish;
	end

endmodule
